/* sv/eatrm_pkg.sv */
`default_nettype none
package eatrm_pkg;

    // Sine and cosine in Q30, signed, range -2^30 .. 2^30
    typedef logic signed [31:0] trig_t;
    // Q60 products and matrix sums
    typedef logic signed [63:0] q60_t;

    // Octant handling: swap sine/cosine and negate either of them
    typedef struct packed {
        logic neg_cos;
        logic neg_sin;
        logic self_sel;
    } oct_map_t;

    localparam int          N_TERMS = 6;
    localparam logic [63:0] PI48    = 64'h0003_243F_6A88_85A3;
    localparam logic [30:0] Q_ONE   = 31'h4000_0000;

    localparam oct_map_t OCT_MAP [8] = '{
        3'b001, 3'b000, 3'b100, 3'b101, 3'b111, 3'b110, 3'b010, 3'b011
    };

    // Taylor divisors, innermost Horner term first
    localparam logic [7:0] SIN_DIV [N_TERMS] = '{
        8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };
    localparam logic [7:0] COS_DIV [N_TERMS] = '{
        8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };

    // floor(2^30 / k): quotient estimate is off by at most one below
    localparam logic [29:0] SIN_RCP [N_TERMS] = '{
        30'(32'h4000_0000 / 156), 30'(32'h4000_0000 / 110),
        30'(32'h4000_0000 / 72),  30'(32'h4000_0000 / 42),
        30'(32'h4000_0000 / 20),  30'(32'h4000_0000 / 6)
    };
    localparam logic [29:0] COS_RCP [N_TERMS] = '{
        30'(32'h4000_0000 / 132), 30'(32'h4000_0000 / 90),
        30'(32'h4000_0000 / 56),  30'(32'h4000_0000 / 30),
        30'(32'h4000_0000 / 12),  30'(32'h4000_0000 / 2)
    };

    // Shift right with rounding to nearest, halves away from zero
    function automatic q60_t round_shift(q60_t v, int unsigned sh);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -q60_t'(mag) : q60_t'(mag);
    endfunction

    // Q60 to output element: round, clamp to +/- one, keep 16 bits
    function automatic logic [15:0] to_field(q60_t v, int unsigned frac);
        q60_t one;
        q60_t r;
        one = q60_t'(64'd1 << frac);
        r   = round_shift(v, 60 - frac);
        if (r > one)
        begin
            r = one;
        end
        if (r < -one)
        begin
            r = -one;
        end
        return r[15:0];
    endfunction

endpackage
`default_nettype wire

/* sv/eatrm_sincos.sv */
`default_nettype none
module eatrm_sincos (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [15:0]     angle,
    output eatrm_pkg::trig_t     sin_val,
    output eatrm_pkg::trig_t     cos_val
);

    localparam int NT   = eatrm_pkg::N_TERMS;
    localparam int LINE = 3 * NT + 1;

    // Stage 1: octant reduction and scaling to Q30 radians
    logic [2:0]            oct;
    logic [13:0]           r;
    logic [63:0]           pr_lo;
    logic [63:0]           pr_hi;
    logic [63:0]           pr;
    logic [29:0]           x1_reg;
    eatrm_pkg::oct_map_t   code1_reg;

    always_comb
    begin
        oct   = angle[15:13];
        r     = oct[0] ? (14'd8192 - {1'b0, angle[12:0]}) : {1'b0, angle[12:0]};
        pr_lo = 64'(r) * 64'(eatrm_pkg::PI48[24:0]);
        pr_hi = 64'(r) * 64'(eatrm_pkg::PI48[49:25]);
        pr    = pr_lo + (pr_hi << 25) + (64'd1 << 32);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= pr[62:33];
            code1_reg <= eatrm_pkg::OCT_MAP[oct];
        end
    end

    // Stage 2: square, then a carry line alongside the term stages
    logic [59:0]           sq;
    logic [29:0]           x_line    [LINE];
    logic [29:0]           x2_line   [LINE];
    eatrm_pkg::oct_map_t   code_line [LINE];

    assign sq = 60'(x1_reg) * 60'(x1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_line[0]    <= x1_reg;
            x2_line[0]   <= sq[59:30];
            code_line[0] <= code1_reg;
            for (int j = 1; j < LINE; j++)
            begin
                x_line[j]    <= x_line[j-1];
                x2_line[j]   <= x2_line[j-1];
                code_line[j] <= code_line[j-1];
            end
        end
    end

    // Horner terms: multiply, reciprocal estimate, correct and subtract
    logic [30:0] ts_arr [NT];
    logic [30:0] tc_arr [NT];

    genvar i;
    generate
        for (i = 0; i < NT; i++)
        begin : g_term
            logic [30:0] ts_in;
            logic [30:0] tc_in;
            logic [60:0] ps_full;
            logic [60:0] pc_full;
            logic [29:0] ps_reg;
            logic [29:0] pc_reg;
            logic [59:0] qs_full;
            logic [59:0] qc_full;
            logic [29:0] qes_reg;
            logic [29:0] qec_reg;
            logic [29:0] pbs_reg;
            logic [29:0] pbc_reg;
            logic [37:0] rem_s;
            logic [37:0] rem_c;
            logic [29:0] q_s;
            logic [29:0] q_c;
            logic [30:0] ts_reg;
            logic [30:0] tc_reg;

            if (i == 0)
            begin : g_first
                assign ts_in = eatrm_pkg::Q_ONE;
                assign tc_in = eatrm_pkg::Q_ONE;
            end
            else
            begin : g_next
                assign ts_in = ts_arr[i-1];
                assign tc_in = tc_arr[i-1];
            end

            assign ps_full = 61'(x2_line[3*i]) * 61'(ts_in);
            assign pc_full = 61'(x2_line[3*i]) * 61'(tc_in);
            assign qs_full = 60'(ps_reg) * 60'(eatrm_pkg::SIN_RCP[i]);
            assign qc_full = 60'(pc_reg) * 60'(eatrm_pkg::COS_RCP[i]);

            always_comb
            begin
                rem_s = 38'(pbs_reg) - 38'(qes_reg) * 38'(eatrm_pkg::SIN_DIV[i]);
                rem_c = 38'(pbc_reg) - 38'(qec_reg) * 38'(eatrm_pkg::COS_DIV[i]);
                q_s   = qes_reg + 30'(rem_s >= 38'(eatrm_pkg::SIN_DIV[i]));
                q_c   = qec_reg + 30'(rem_c >= 38'(eatrm_pkg::COS_DIV[i]));
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ps_reg  <= ps_full[59:30];
                    pc_reg  <= pc_full[59:30];
                    qes_reg <= qs_full[59:30];
                    qec_reg <= qc_full[59:30];
                    pbs_reg <= ps_reg;
                    pbc_reg <= pc_reg;
                    ts_reg  <= eatrm_pkg::Q_ONE - 31'(q_s);
                    tc_reg  <= eatrm_pkg::Q_ONE - 31'(q_c);
                end
            end

            assign ts_arr[i] = ts_reg;
            assign tc_arr[i] = tc_reg;
        end
    endgenerate

    // Final sine multiply
    logic [60:0]           tsf_full;
    logic [30:0]           tsf_reg;
    logic [30:0]           tcf_reg;
    eatrm_pkg::oct_map_t   codef_reg;

    assign tsf_full = 61'(x_line[LINE-1]) * 61'(ts_arr[NT-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tsf_reg   <= tsf_full[60:30];
            tcf_reg   <= tc_arr[NT-1];
            codef_reg <= code_line[LINE-1];
        end
    end

    // Octant swap and sign
    eatrm_pkg::trig_t vs_next;
    eatrm_pkg::trig_t vc_next;
    eatrm_pkg::trig_t vs_reg;
    eatrm_pkg::trig_t vc_reg;

    always_comb
    begin
        vs_next = codef_reg.self_sel ? 32'({1'b0, tsf_reg}) : 32'({1'b0, tcf_reg});
        vc_next = codef_reg.self_sel ? 32'({1'b0, tcf_reg}) : 32'({1'b0, tsf_reg});
        if (codef_reg.neg_sin)
        begin
            vs_next = -vs_next;
        end
        if (codef_reg.neg_cos)
        begin
            vc_next = -vc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vs_reg <= vs_next;
            vc_reg <= vc_next;
        end
    end

    assign sin_val = vs_reg;
    assign cos_val = vc_reg;

endmodule
`default_nettype wire

/* sv/eatrm_matrix.sv */
`default_nettype none
module eatrm_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire eatrm_pkg::trig_t  sb,
    input  wire eatrm_pkg::trig_t  cb,
    input  wire eatrm_pkg::trig_t  sp,
    input  wire eatrm_pkg::trig_t  cp,
    input  wire eatrm_pkg::trig_t  sh,
    input  wire eatrm_pkg::trig_t  ch,
    output logic [8:0][15:0]       elems
);

    // Direct products kept to the summing stage:
    // cp*ch, cp*sh, sb*cp, cb*cp, sb*sh, cb*sh, sb*ch, cb*ch
    eatrm_pkg::q60_t  pr1_reg [8];
    eatrm_pkg::q60_t  pr2_reg [8];
    eatrm_pkg::q60_t  pr3_reg [8];
    eatrm_pkg::q60_t  spch1_reg;
    eatrm_pkg::q60_t  spsh1_reg;
    eatrm_pkg::trig_t sb1_reg, cb1_reg, sp1_reg;
    eatrm_pkg::trig_t sb2_reg, cb2_reg, sp2_reg;
    eatrm_pkg::trig_t spch2_reg, spsh2_reg;
    eatrm_pkg::trig_t sp3_reg;
    eatrm_pkg::q60_t  sbspch3_reg, sbspsh3_reg, cbspch3_reg, cbspsh3_reg;
    eatrm_pkg::q60_t  e4_reg [9];
    logic [8:0][15:0] out_reg;

    // Stage M1: all first-level products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spch1_reg  <= 64'(sp) * 64'(ch);
            spsh1_reg  <= 64'(sp) * 64'(sh);
            pr1_reg[0] <= 64'(cp) * 64'(ch);
            pr1_reg[1] <= 64'(cp) * 64'(sh);
            pr1_reg[2] <= 64'(sb) * 64'(cp);
            pr1_reg[3] <= 64'(cb) * 64'(cp);
            pr1_reg[4] <= 64'(sb) * 64'(sh);
            pr1_reg[5] <= 64'(cb) * 64'(sh);
            pr1_reg[6] <= 64'(sb) * 64'(ch);
            pr1_reg[7] <= 64'(cb) * 64'(ch);
            sb1_reg    <= sb;
            cb1_reg    <= cb;
            sp1_reg    <= sp;
        end
    end

    // Stage M2: round sp*ch and sp*sh back to Q30
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spch2_reg <= 32'(eatrm_pkg::round_shift(spch1_reg, 30));
            spsh2_reg <= 32'(eatrm_pkg::round_shift(spsh1_reg, 30));
            pr2_reg   <= pr1_reg;
            sb2_reg   <= sb1_reg;
            cb2_reg   <= cb1_reg;
            sp2_reg   <= sp1_reg;
        end
    end

    // Stage M3: second-level products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sbspch3_reg <= 64'(sb2_reg) * 64'(spch2_reg);
            sbspsh3_reg <= 64'(sb2_reg) * 64'(spsh2_reg);
            cbspch3_reg <= 64'(cb2_reg) * 64'(spch2_reg);
            cbspsh3_reg <= 64'(cb2_reg) * 64'(spsh2_reg);
            pr3_reg     <= pr2_reg;
            sp3_reg     <= sp2_reg;
        end
    end

    // Stage M4: element sums in Q60
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e4_reg[0] <= pr3_reg[0];
            e4_reg[1] <= pr3_reg[1];
            e4_reg[2] <= -(64'(sp3_reg) <<< 30);
            e4_reg[3] <= sbspch3_reg - pr3_reg[5];
            e4_reg[4] <= pr3_reg[7] + sbspsh3_reg;
            e4_reg[5] <= pr3_reg[2];
            e4_reg[6] <= pr3_reg[4] + cbspch3_reg;
            e4_reg[7] <= cbspsh3_reg - pr3_reg[6];
            e4_reg[8] <= pr3_reg[3];
        end
    end

    // Stage M5: round, clamp, output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                out_reg[k] <= eatrm_pkg::to_field(e4_reg[k], FRAC_BITS);
            end
        end
    end

    assign elems = out_reg;

endmodule
`default_nettype wire

/* sv/euler_angles_to_rotation_matrix_top.sv */
`default_nettype none
// Orientation matrix from three binary angles (bank about x, pitch about y,
// heading about z, 65536 counts per turn): Rz(heading) * Ry(pitch) * Rx(bank),
// nine signed elements with FRAC_BITS fraction bits, rounded and clamped to
// +/- one. Fully pipelined: one beat in and one beat out per cycle while
// results are taken, passing octant reduction, the six-term sine/cosine
// Horner pipeline, then the matrix products, sums and rounding. The whole
// pipeline advances together; it holds while a result beat waits unaccepted.
module euler_angles_to_rotation_matrix_top #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // bank_angle[15:0], pitch_angle[31:16], heading_angle[47:32]
    input  wire logic [47:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // elem_0[15:0], elem_1[31:16], ... elem_8[143:128]
    output logic [143:0]      m_axis_tdata
);

    localparam int LAT = 27;

    logic             en;
    logic [LAT-1:0]   vld_reg;
    logic [LAT-1:0]   vld_next;
    logic [8:0][15:0] elems;
    eatrm_pkg::trig_t sb, cb, sp, cp, sh, ch;

    // Global advance: move when the output slot is free or being taken
    assign en = !vld_reg[LAT-1] || m_axis_tready;

    assign vld_next = {vld_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    eatrm_sincos u_bank (
        .clk     (clk),
        .en      (en),
        .angle   (s_axis_tdata[15:0]),
        .sin_val (sb),
        .cos_val (cb)
    );

    eatrm_sincos u_pitch (
        .clk     (clk),
        .en      (en),
        .angle   (s_axis_tdata[31:16]),
        .sin_val (sp),
        .cos_val (cp)
    );

    eatrm_sincos u_heading (
        .clk     (clk),
        .en      (en),
        .angle   (s_axis_tdata[47:32]),
        .sin_val (sh),
        .cos_val (ch)
    );

    eatrm_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .clk   (clk),
        .en    (en),
        .sb    (sb),
        .cb    (cb),
        .sp    (sp),
        .cp    (cp),
        .sh    (sh),
        .ch    (ch),
        .elems (elems)
    );

    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = elems;

`ifndef ASSERT_OFF
    // a held pipeline keeps its occupancy
    a_hold_vld: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved while stalled");

    // an accepted beat enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted beat lost at entry");

    // clamped elements stay within +/- one
    a_elem2_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && FRAC_BITS <= 14 |->
        $signed(m_axis_tdata[47:32]) <= 16'sd16384 &&
        $signed(m_axis_tdata[47:32]) >= -16'sd16384)
        else $error("elem_2 out of range");

    a_elem8_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && FRAC_BITS <= 14 |->
        $signed(m_axis_tdata[143:128]) <= 16'sd16384 &&
        $signed(m_axis_tdata[143:128]) >= -16'sd16384)
        else $error("elem_8 out of range");
`endif

endmodule
`default_nettype wire
